FILE: hdl/appv_pkg.sv
package appv_pkg;

  // packet layout
  localparam int unsigned HdrBytes     = 9;
  localparam int unsigned HdrIdxW      = $clog2(HdrBytes);
  localparam int unsigned CntW         = 9;
  localparam int unsigned CountMax     = (1 << CntW) - 1;
  localparam int unsigned SumW         = 9;
  localparam int unsigned LenFirstIdx  = 7;
  localparam int unsigned LenSecondIdx = 8;

  // frames per packet, default for the top level parameter
  localparam int unsigned MaxFramesDef = 2;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC       = 8'd0,
    CFG_VERSION     = 8'd1,
    CFG_AUDIO_TYPE  = 8'd2,
    CFG_END_TYPE    = 8'd3,
    CFG_FLAG_MASK   = 8'd4,
    CFG_END_REASON  = 8'd5,
    CFG_MAX_PAYLOAD = 8'd6,
    CFG_MAX_PACKET  = 8'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] version;
    logic [7:0] audio_type;
    logic [7:0] end_type;
    logic [7:0] flag_mask;
    logic [7:0] end_reason;
    logic [7:0] max_payload;
    logic [7:0] max_packet;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    magic:       8'd0,
    version:     8'd0,
    audio_type:  8'd0,
    end_type:    8'd1,
    flag_mask:   8'd1,
    end_reason:  8'd1,
    max_payload: 8'd246,
    max_packet:  8'd255
  };

  // one finished packet as seen by the front part
  typedef struct packed {
    logic [HdrBytes-1:0][7:0] hdr;
    logic [CntW-1:0]          len;
    logic [SumW-1:0]          len_sum;
    logic                     overlen;
  } pkt_rec_t;

  // handshake between front part and queue
  typedef struct packed {
    logic push;
  } q_wr_ctl_t;

  typedef struct packed {
    logic full;
  } q_wr_sts_t;

endpackage

FILE: hdl/appv_channels.sv
interface appv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface appv_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        packet_kind;
  logic [15:0] seq_number;
  logic [7:0]  flag_bits;
  logic [1:0]  frames_in_packet;
  logic [7:0]  first_frame_length;
  logic [7:0]  second_frame_length;
  logic [15:0] session_number;
  logic [15:0] closing_sequence;
  logic [7:0]  end_reason;

  modport source (
    output valid, input ready,
    output status, output packet_kind, output seq_number, output flag_bits,
    output frames_in_packet, output first_frame_length, output second_frame_length,
    output session_number, output closing_sequence, output end_reason
  );
  modport sink (
    input valid, output ready,
    input status, input packet_kind, input seq_number, input flag_bits,
    input frames_in_packet, input first_frame_length, input second_frame_length,
    input session_number, input closing_sequence, input end_reason
  );
endinterface

interface appv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [appv_pkg::CfgIdxW-1:0]  index;
  logic [appv_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/appv_front.sv
module appv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  appv_in_if.sink             rx_i,
  output appv_pkg::q_wr_ctl_t q_ctl_o,
  input  appv_pkg::q_wr_sts_t q_sts_i,
  output appv_pkg::pkt_rec_t  rec_o
);
  import appv_pkg::*;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [HdrBytes-1:0][7:0] hdr_q, hdr_d;
  logic [SumW-1:0]          sum_q, sum_d;
  logic                     ovl_q, ovl_d;
  logic                     accept;
  logic                     in_hdr;
  logic                     is_len_byte;

  assign rx_i.ready = !q_sts_i.full;
  assign accept     = rx_i.valid && rx_i.ready;

  // header capture and running frame length sum
  assign in_hdr      = cnt_q < CntW'(HdrBytes);
  assign is_len_byte = (cnt_q == CntW'(LenFirstIdx)) || (cnt_q == CntW'(LenSecondIdx));

  always_comb begin
    hdr_d = hdr_q;
    if (in_hdr) begin
      hdr_d[cnt_q[HdrIdxW-1:0]] = rx_i.rx_byte;
    end
    sum_d = sum_q;
    if (in_hdr && is_len_byte) begin
      sum_d = sum_q + SumW'(rx_i.rx_byte);
    end
    // saturating count, overlength flag once the top is hit
    if (cnt_q == CntW'(CountMax)) begin
      cnt_d = cnt_q;
      ovl_d = 1'b1;
    end else begin
      cnt_d = cnt_q + 1'b1;
      ovl_d = ovl_q;
    end
  end

  // finished packet word for the queue
  assign q_ctl_o.push  = accept && rx_i.last_byte;
  assign rec_o.hdr     = hdr_d;
  assign rec_o.len     = cnt_d;
  assign rec_o.len_sum = sum_d;
  assign rec_o.overlen = ovl_d;

  // packet state, cleared after every last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hdr_q <= '0;
      sum_q <= '0;
      ovl_q <= 1'b0;
    end else if (accept) begin
      if (rx_i.last_byte) begin
        cnt_q <= '0;
        hdr_q <= '0;
        sum_q <= '0;
        ovl_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        hdr_q <= hdr_d;
        sum_q <= sum_d;
        ovl_q <= ovl_d;
      end
    end
  end

endmodule

FILE: hdl/appv_queue.sv
module appv_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  appv_pkg::q_wr_ctl_t wr_ctl_i,
  output appv_pkg::q_wr_sts_t wr_sts_o,
  input  appv_pkg::pkt_rec_t  wr_rec_i,
  input  logic                pop_i,
  output logic                empty_o,
  output appv_pkg::pkt_rec_t  rd_rec_o
);
  import appv_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntQW = $clog2(QueueDepth + 1);

  pkt_rec_t             mem_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0]     cnt_q;
  logic                 do_push, do_pop;

  assign wr_sts_o.full = cnt_q == CntQW'(QueueDepth);
  assign empty_o       = cnt_q == '0;
  assign rd_rec_o      = mem_q[rd_ptr_q];
  assign do_push       = wr_ctl_i.push && !wr_sts_o.full;
  assign do_pop        = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/appv_back.sv
module appv_back #(
  parameter int unsigned MAX_FRAMES = appv_pkg::MaxFramesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  appv_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  appv_pkg::pkt_rec_t q_rec_i,
  output logic               q_pop_o,
  appv_out_if.source         res_o
);
  import appv_pkg::*;

  logic              out_valid_q;
  logic              load;
  logic [7:0]        h0, h1, h2, h3, h4, h5, h6, h7, h8;
  logic [CntW-1:0]   len;
  logic              len_ok_audio, hdr_ok_audio, frame_ok, audio_ok, end_ok;
  logic              is_audio, is_end;
  logic [7:0]        room;

  // pop when the output register is free or being drained
  assign load    = !q_empty_i && (!out_valid_q || res_o.ready);
  assign q_pop_o = load;

  assign h0  = q_rec_i.hdr[0];
  assign h1  = q_rec_i.hdr[1];
  assign h2  = q_rec_i.hdr[2];
  assign h3  = q_rec_i.hdr[3];
  assign h4  = q_rec_i.hdr[4];
  assign h5  = q_rec_i.hdr[5];
  assign h6  = q_rec_i.hdr[6];
  assign h7  = q_rec_i.hdr[7];
  assign h8  = q_rec_i.hdr[8];
  assign len = q_rec_i.len;

  // audio layout checks
  assign room = cfg_i.max_payload - h7;

  assign len_ok_audio = (len >= CntW'(HdrBytes)) && (len <= CntW'(cfg_i.max_packet))
                      && !q_rec_i.overlen;
  assign hdr_ok_audio = (h0 == cfg_i.magic) && (h1 == cfg_i.version)
                      && (h2 == cfg_i.audio_type) && ((h3 & ~cfg_i.flag_mask) == 8'd0);
  assign frame_ok = (h4 != 8'd0) && (h4 <= 8'(MAX_FRAMES))
                  && !((h4 == 8'd1) && (h8 != 8'd0))
                  && (h7 != 8'd0) && (h7 <= cfg_i.max_payload)
                  && !((h4 == 8'd2) && ((h8 == 8'd0) || (h8 > room)));
  assign audio_ok = len_ok_audio && hdr_ok_audio && frame_ok
                  && ((CntW + 1)'(len) == (CntW + 1)'(HdrBytes) + (CntW + 1)'(q_rec_i.len_sum));

  // end-of-session checks
  assign end_ok = (len == CntW'(HdrBytes)) && !q_rec_i.overlen
                && (h0 == cfg_i.magic) && (h1 == cfg_i.version)
                && (h2 == cfg_i.end_type) && (h3 == cfg_i.end_reason) && (h8 == 8'd0);

  // audio code wins when both type codes match
  assign is_audio = h2 == cfg_i.audio_type;
  assign is_end   = !is_audio && (h2 == cfg_i.end_type);

  assign res_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // verdict and decoded fields
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_o.status              <= 1'b1;
      res_o.packet_kind         <= 1'b0;
      res_o.seq_number          <= '0;
      res_o.flag_bits           <= '0;
      res_o.frames_in_packet    <= '0;
      res_o.first_frame_length  <= '0;
      res_o.second_frame_length <= '0;
      res_o.session_number      <= '0;
      res_o.closing_sequence    <= '0;
      res_o.end_reason          <= '0;
      if (is_audio && audio_ok) begin
        res_o.status              <= 1'b0;
        res_o.seq_number          <= {h6, h5};
        res_o.flag_bits           <= h3;
        res_o.frames_in_packet    <= h4[1:0];
        res_o.first_frame_length  <= h7;
        res_o.second_frame_length <= h8;
      end else if (is_end && end_ok) begin
        res_o.status           <= 1'b0;
        res_o.packet_kind      <= 1'b1;
        res_o.session_number   <= {h5, h4};
        res_o.closing_sequence <= {h7, h6};
        res_o.end_reason       <= h3;
      end
    end
  end

endmodule

FILE: hdl/audio_packet_parse_validate.sv
// Audio packet parser and validator. Packet words (one byte each, the final one
// marked by last_byte) are taken at one per clock with no gaps required between
// packets. The front part keeps the nine header bytes, a saturating byte count
// and the frame length sum; on the last word it hands the packet summary to a
// two-entry queue. The back part checks the summary against the audio or the
// end-of-session layout and registers one verdict per packet, taken from the
// queue head. The only stall source is the result side: once the output
// register and the queue are both full, ready drops. Payload bytes are
// counted and dropped. Configuration writes are always ready; writes to an
// index past the last register are ignored.
module audio_packet_parse_validate #(
  parameter int unsigned MAX_FRAMES = appv_pkg::MaxFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  appv_in_if.sink     rx_i,
  appv_out_if.source  res_o,
  appv_cfg_if.sink    cfg_i
);
  import appv_pkg::*;

  cfg_t      cfg_q;
  q_wr_ctl_t q_ctl;
  q_wr_sts_t q_sts;
  pkt_rec_t  wr_rec, rd_rec;
  logic      q_empty, q_pop;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_MAGIC:       cfg_q.magic       <= cfg_i.data;
        CFG_VERSION:     cfg_q.version     <= cfg_i.data;
        CFG_AUDIO_TYPE:  cfg_q.audio_type  <= cfg_i.data;
        CFG_END_TYPE:    cfg_q.end_type    <= cfg_i.data;
        CFG_FLAG_MASK:   cfg_q.flag_mask   <= cfg_i.data;
        CFG_END_REASON:  cfg_q.end_reason  <= cfg_i.data;
        CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_i.data;
        CFG_MAX_PACKET:  cfg_q.max_packet  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  appv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .q_ctl_o (q_ctl),
    .q_sts_i (q_sts),
    .rec_o   (wr_rec)
  );

  appv_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_ctl_i (q_ctl),
    .wr_sts_o (q_sts),
    .wr_rec_i (wr_rec),
    .pop_i    (q_pop),
    .empty_o  (q_empty),
    .rd_rec_o (rd_rec)
  );

  appv_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_rec_i   (rd_rec),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule
